[sv/audio_noise_gate_hold_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the noise gate with hold
// Shared property wrappers, clocked on the rising edge, off during reset.
// ---------------------------------------------------------------------------
`ifndef AUDIO_NOISE_GATE_HOLD_ASSERT_SVH
`define AUDIO_NOISE_GATE_HOLD_ASSERT_SVH

// same-cycle implication
`define ANGH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ANGH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/angh_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Noise gate package
// Default widths, register indexes and the status structs shared by the
// gate detector, the bit-serial multiplier and the top level.
// ---------------------------------------------------------------------------
package angh_pkg;

	localparam int SAMPLE_BITS_DEF = 24;
	localparam int HOLD_BITS_DEF   = 16;
	localparam int COEF_BITS       = 24;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 2'd3;

	// multiplier status: finish pulse plus the rounding bits shifted out
	typedef struct packed {
		logic done;
		logic last;    // most recent bit shifted out of the product
		logic sticky;  // OR of all earlier bits shifted out
	} mul_flags_t;

	// gate decision for one sample
	typedef struct packed {
		logic neg;
		logic open;
	} gate_flags_t;

endpackage

[sv/angh_gate_detect.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Gate detector
// Takes the magnitude of a signed sample and compares it with the
// threshold, clamped to one, to form the gate target.
// ---------------------------------------------------------------------------
module angh_gate_detect #(
	parameter int SAMPLE_BITS = angh_pkg::SAMPLE_BITS_DEF
) (
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [SAMPLE_BITS-1:0] threshold,
	output logic [SAMPLE_BITS-1:0] mag,
	output angh_pkg::gate_flags_t  flags
);
	import angh_pkg::*;

	localparam logic [SAMPLE_BITS-1:0] ONE = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

	logic [SAMPLE_BITS-1:0] thr_c;

	// clamp threshold to one
	assign thr_c = (threshold > ONE) ? ONE : threshold;

	// negate in place; the most negative sample maps to one
	assign mag = sample[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - sample) : sample;

	assign flags.neg  = sample[SAMPLE_BITS-1];
	assign flags.open = (mag >= thr_c);

endmodule

[sv/angh_serial_mul.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bit-serial multiplier
// Shift-add unit: one multiplier bit per cycle, product shifted right so
// only a W+1 bit adder is needed. Bits shifted out feed rounding flags.
// ---------------------------------------------------------------------------
module angh_serial_mul #(
	parameter int W  = angh_pkg::SAMPLE_BITS_DEF,
	parameter int YW = angh_pkg::COEF_BITS,
	parameter int CW = $clog2(YW + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [CW-1:0]        n,
	input  logic [W-1:0]         x,
	input  logic [YW-1:0]        y,
	output logic [W-1:0]         p,
	output angh_pkg::mul_flags_t flags
);
	import angh_pkg::*;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  x_q;
	logic [YW-1:0] y_q;
	logic [W-1:0]  p_q;
	logic          last_q;
	logic          sticky_q;
	logic [W:0]    sum;

	// add the multiplicand when the current multiplier bit is set
	assign sum = {1'b0, p_q} + (y_q[0] ? {1'b0, x_q} : {(W+1){1'b0}});

	// sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= n;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: load on start, shift one bit per cycle while busy
	always_ff @(posedge clk) begin
		if (start) begin
			x_q      <= x;
			y_q      <= y;
			p_q      <= '0;
			last_q   <= 1'b0;
			sticky_q <= 1'b0;
		end else if (busy_q) begin
			p_q      <= sum[W:1];
			last_q   <= sum[0];
			sticky_q <= sticky_q | last_q;
			y_q      <= y_q >> 1;
		end
	end

	assign p            = p_q;
	assign flags.done   = done_q;
	assign flags.last   = last_q;
	assign flags.sticky = sticky_q;

endmodule

[sv/audio_noise_gate_hold.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Noise gate with hold
// Gates a signed audio stream with a smoothed gain, held open for a set
// number of samples after the signal drops below the threshold.
// ---------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid/in_stall) carry one signed sample each; output
//   beats (out_valid/out_stall) carry the gated sample and the gain after it.
//   One item is in work at a time; in_stall stays high from acceptance until
//   the result has moved into the output register.
//   When the gain is smoothed, both products go through one bit-serial
//   multiplier, one bit per cycle: first coefficient times gain, then
//   magnitude times gain. While the hold counter runs, only the second
//   product is formed.
//   Configuration (cfg_we/cfg_index/cfg_data) is written while idle; unused
//   indexes are ignored.
//   Reset clears config, state, gain, hold counter and out_valid; no item is
//   pending afterwards. A stalled result holds in the output register, and
//   the next item may already be accepted and worked on behind it.
// ---------------------------------------------------------------------------
module audio_noise_gate_hold #(
	parameter int SAMPLE_BITS = angh_pkg::SAMPLE_BITS_DEF,
	parameter int HOLD_BITS   = angh_pkg::HOLD_BITS_DEF,
	localparam int CFG_W =
		(SAMPLE_BITS > angh_pkg::COEF_BITS) ?
		((SAMPLE_BITS > HOLD_BITS) ? SAMPLE_BITS : HOLD_BITS) :
		((angh_pkg::COEF_BITS > HOLD_BITS) ? angh_pkg::COEF_BITS : HOLD_BITS)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [angh_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_W-1:0]                    cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [SAMPLE_BITS-1:0]       in_sample,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [SAMPLE_BITS-1:0]       out_sample,
	output logic [SAMPLE_BITS-1:0]              gain_now
);
	import angh_pkg::*;

	localparam int S     = SAMPLE_BITS;
	localparam int YW    = (COEF_BITS > S) ? COEF_BITS : S;
	localparam int CW    = $clog2(YW + 1);
	localparam logic [S-1:0] ONE = S'(1) << (S - 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SMOOTH = 2'd1;
	localparam logic [1:0] ST_OUTMUL = 2'd2;
	localparam logic [1:0] ST_EMIT   = 2'd3;

	// configuration
	logic [S-1:0]         thr_q;
	logic [COEF_BITS-1:0] att_q;
	logic [COEF_BITS-1:0] rel_q;
	logic [HOLD_BITS-1:0] hold_len_q;

	// state
	logic [1:0]           state_q;
	logic [S-1:0]         gain_q;
	logic [HOLD_BITS:0]   hold_cnt_q;
	logic [S-1:0]         mag_q;
	logic                 neg_q;
	logic                 tgt_q;
	logic [S-1:0]         res_q;

	// output register
	logic                 out_valid_q;
	logic [S-1:0]         out_sample_q;
	logic [S-1:0]         gain_out_q;

	logic                 accept;
	logic [S-1:0]         mag;
	gate_flags_t          gate;
	logic                 tgt_below;
	logic                 hold_gt;
	logic                 out_free;

	logic                 mul_start;
	logic [CW-1:0]        mul_n;
	logic [S-1:0]         mul_x;
	logic [YW-1:0]        mul_y;
	logic [S-1:0]         mul_p;
	mul_flags_t           mul_f;

	logic [S:0]           ceil_p;
	logic [S-1:0]         gain_next;
	logic [S:0]           q_out;
	logic [S-1:0]         res_next;

	angh_gate_detect #(
		.SAMPLE_BITS(S)
	) u_detect (
		.sample   (in_sample),
		.threshold(thr_q),
		.mag      (mag),
		.flags    (gate)
	);

	angh_serial_mul #(
		.W (S),
		.YW(YW),
		.CW(CW)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.n     (mul_n),
		.x     (mul_x),
		.y     (mul_y),
		.p     (mul_p),
		.flags (mul_f)
	);

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	// target is zero or one, so it is below the gain only when closed and gain nonzero
	assign tgt_below = !gate.open && (gain_q != '0);
	assign hold_gt   = (hold_cnt_q > {1'b0, hold_len_q});

	// smoothing result: floor for a closing target, one minus ceiling when opening
	assign ceil_p    = {1'b0, mul_p} + {{S{1'b0}}, (mul_f.sticky | mul_f.last)};
	assign gain_next = tgt_q ? (ONE - ceil_p[S-1:0]) : mul_p;

	// output product divided by one, rounded toward minus infinity
	assign q_out    = {mul_p, mul_f.last} + {{S{1'b0}}, (neg_q & mul_f.sticky)};
	assign res_next = neg_q ? (S'(0) - q_out[S-1:0]) : q_out[S-1:0];

	// steer the shared multiplier
	always_comb begin
		mul_start = 1'b0;
		mul_n     = CW'(S);
		mul_x     = mag_q;
		mul_y     = YW'(gain_next);
		if (accept) begin
			mul_start = 1'b1;
			if (tgt_below && !hold_gt) begin
				mul_n = CW'(S);
				mul_x = mag;
				mul_y = YW'(gain_q);
			end else begin
				mul_n = CW'(COEF_BITS);
				mul_x = gate.open ? (ONE - gain_q) : gain_q;
				mul_y = tgt_below ? YW'(att_q) : YW'(rel_q);
			end
		end else if (state_q == ST_SMOOTH && mul_f.done) begin
			mul_start = 1'b1;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= '0;
			att_q      <= '0;
			rel_q      <= '0;
			hold_len_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD: thr_q      <= cfg_data[S-1:0];
				REG_ATTACK:    att_q      <= cfg_data[COEF_BITS-1:0];
				REG_RELEASE:   rel_q      <= cfg_data[COEF_BITS-1:0];
				REG_HOLD:      hold_len_q <= cfg_data[HOLD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// sequencer, gain and hold counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			gain_q     <= '0;
			hold_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (tgt_below && !hold_gt) begin
							hold_cnt_q <= hold_cnt_q + (HOLD_BITS+1)'(1);
							state_q    <= ST_OUTMUL;
						end else begin
							if (!tgt_below) begin
								hold_cnt_q <= '0;
							end
							state_q <= ST_SMOOTH;
						end
					end
				end
				ST_SMOOTH: begin
					if (mul_f.done) begin
						gain_q  <= gain_next;
						state_q <= ST_OUTMUL;
					end
				end
				ST_OUTMUL: begin
					if (mul_f.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// per-item payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= mag;
			neg_q <= gate.neg;
			tgt_q <= gate.open;
		end
		if (state_q == ST_OUTMUL && mul_f.done) begin
			res_q <= res_next;
		end
	end

	// output register: drop on a taken beat, load from the emit state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			out_sample_q <= res_q;
			gain_out_q   <= gain_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;
	assign gain_now   = gain_out_q;

endmodule

[sv/angh_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Noise gate port checker
// Watches the top-level ports for stall behavior, gain range, silence at zero
// gain and the one-item-at-a-time input handshake.
// ---------------------------------------------------------------------------
`include "audio_noise_gate_hold_assert.svh"

module angh_checker #(
	parameter int SAMPLE_BITS = angh_pkg::SAMPLE_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic signed [SAMPLE_BITS-1:0] out_sample,
	input logic [SAMPLE_BITS-1:0]        gain_now
);
	import angh_pkg::*;

	localparam logic [SAMPLE_BITS-1:0] ONE = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

	// a stalled result beat holds
	`ANGH_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(out_sample) && $stable(gain_now), "stalled output changed")

	// gain never exceeds one
	`ANGH_ASSERT_IMP(a_gain_range, clk, arst_n, out_valid, gain_now <= ONE,
		"gain above one")

	// a closed gate passes silence
	`ANGH_ASSERT_IMP(a_zero_gain, clk, arst_n, out_valid && (gain_now == '0),
		out_sample == '0, "nonzero sample at zero gain")

	// an accepted beat keeps the input stalled while it is worked on
	`ANGH_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall,
		in_stall, "input not stalled after accept")

endmodule

bind audio_noise_gate_hold angh_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_angh_checker (.*);

[test/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Noise gate with hold testbench
// Streams signed samples through the gate under changing thresholds,
// coefficients and hold lengths, predicts each gated sample and gain with a
// cycle-free model of the gate, and checks every output beat in order.
// ---------------------------------------------------------------------------
module tb;
	import angh_pkg::*;

	localparam int SW = SAMPLE_BITS_DEF;
	localparam int HW = HOLD_BITS_DEF;
	localparam int CW = (SW > COEF_BITS) ? SW : COEF_BITS;
	localparam logic [63:0] ONE = 64'd1 << (SW - 1);
	localparam logic [63:0] COEF_ONE = 64'd1 << COEF_BITS;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int SETTLE_CYCLES = 60;

	typedef enum logic [1:0] {PACE_SRC_LIGHT, PACE_SRC_HEAVY, PACE_FREE} pace_t;

	typedef struct packed {
		logic signed [SW-1:0] smp;
		logic [SW-1:0]        gain;
	} gated_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CW-1:0]         cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic signed [SW-1:0]  in_sample = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic signed [SW-1:0]  out_sample;
	logic [SW-1:0]         gain_now;

	// mirrored registers and gate state
	logic [SW-1:0]        thr_reg = '0;
	logic [COEF_BITS-1:0] att_reg = '0;
	logic [COEF_BITS-1:0] rel_reg = '0;
	logic [HW-1:0]        hold_reg = '0;
	logic [SW-1:0]        gain_st = '0;
	logic [HW:0]          hold_st = '0;

	pace_t         pace = PACE_SRC_LIGHT;
	logic [SW-1:0] sample_backlog[$];
	gated_t        gated_due[$];
	int            errors = 0;
	int            quiet_cycles = 0;
	int            holdoff_left = 0;
	bit            holdoff_done = 1'b0;

	audio_noise_gate_hold dut (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int idle_pct(input pace_t p, input bit sender);
		case (p)
			PACE_SRC_LIGHT: return sender ? 21 : 69;
			PACE_SRC_HEAVY: return sender ? 69 : 21;
			default:        return 0;
		endcase
	endfunction

	// one-pole step toward the target, floored, never above one
	function automatic logic [SW-1:0] ease_gain(input logic [COEF_BITS-1:0] a,
			input logic [SW-1:0] g, input logic [63:0] target);
		logic [63:0] acc;
		acc = 64'(a) * 64'(g) + (COEF_ONE - 64'(a)) * target;
		acc = acc >> COEF_BITS;
		return (acc > ONE) ? SW'(ONE) : acc[SW-1:0];
	endfunction

	// advance the gate by one sample and return the gated beat
	function automatic gated_t gate_step(input logic [SW-1:0] raw);
		logic        neg;
		logic [63:0] mag;
		logic [63:0] thr;
		logic [63:0] target;
		logic [63:0] prod;
		logic [63:0] q;
		gated_t      r;
		neg = raw[SW-1];
		mag = neg ? ((ONE << 1) - 64'(raw)) : 64'(raw);
		thr = (64'(thr_reg) > ONE) ? ONE : 64'(thr_reg);
		target = (mag >= thr) ? ONE : 64'd0;
		if (target < 64'(gain_st)) begin
			if (hold_st > {1'b0, hold_reg})
				gain_st = ease_gain(att_reg, gain_st, target);
			else
				hold_st = hold_st + 1'b1;
		end else begin
			hold_st = '0;
			gain_st = ease_gain(rel_reg, gain_st, target);
		end
		prod = mag * 64'(gain_st);
		if (neg) begin
			q = (prod + (ONE - 1)) >> (SW - 1);
			r.smp = SW'(64'd0 - q);
		end else begin
			q = prod >> (SW - 1);
			r.smp = SW'(q);
		end
		r.gain = gain_st;
		return r;
	endfunction

	// write all four registers back to back, then mirror them
	task automatic program_gate(input logic [CW-1:0] thr, input logic [COEF_BITS-1:0] att,
			input logic [COEF_BITS-1:0] rel, input logic [HW-1:0] hold);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_THRESHOLD;
		cfg_data  <= thr;
		@(posedge clk);
		cfg_index <= REG_ATTACK;
		cfg_data  <= CW'(att);
		@(posedge clk);
		cfg_index <= REG_RELEASE;
		cfg_data  <= CW'(rel);
		@(posedge clk);
		cfg_index <= REG_HOLD;
		cfg_data  <= CW'(hold);
		@(posedge clk);
		cfg_we    <= 1'b0;
		thr_reg  = thr[SW-1:0];
		att_reg  = att;
		rel_reg  = rel;
		hold_reg = hold;
	endtask

	// wait until every sample is in and every beat is out
	task automatic drain();
		@(posedge clk);
		while (sample_backlog.size() != 0 || in_valid || gated_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// runs of loud and quiet samples around the threshold, some pure noise
	task automatic queue_bursts(input int count);
		int          left;
		int          run;
		int          kind;
		logic [63:0] thr;
		logic [63:0] mag;
		bit          neg;
		logic [SW-1:0] smp;
		thr = (64'(thr_reg) > ONE) ? ONE : 64'(thr_reg);
		left = count;
		while (left > 0) begin
			kind = $urandom_range(7);
			run = (kind == 0) ? $urandom_range(1, 6) : $urandom_range(1, 24);
			if (run > left)
				run = left;
			repeat (run) begin
				if (kind == 0) begin
					smp = SW'($urandom);
				end else begin
					if (kind <= 3 || thr == 0)
						mag = 64'($urandom_range(32'(ONE), 32'(thr)));
					else
						mag = 64'($urandom_range(32'(thr - 1), 0));
					neg = $urandom_range(1);
					if (neg)
						smp = SW'(64'd0 - mag);
					else
						smp = (mag >= ONE) ? SW'(ONE - 1) : mag[SW-1:0];
				end
				sample_backlog.push_back(smp);
			end
			left -= run;
		end
	endtask

	// input side: predict on each accepted beat, then offer the next sample
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				gated_due.push_back(gate_step(in_sample));
			if (!in_valid || !in_stall) begin
				if (sample_backlog.size() != 0 &&
						$urandom_range(99) >= idle_pct(pace, 1'b1)) begin
					in_valid  <= 1'b1;
					in_sample <= sample_backlog.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output side: check each beat against the oldest prediction
	always @(posedge clk) begin
		gated_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (gated_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat, expected none, got sample %h gain %h",
						$time, out_sample, gain_now);
				end else begin
					want = gated_due.pop_front();
					if (out_sample !== want.smp) begin
						errors++;
						$display("%0t: out_sample expected %h got %h",
							$time, want.smp, out_sample);
					end
					if (gain_now !== want.gain) begin
						errors++;
						$display("%0t: gain_now expected %h got %h",
							$time, want.gain, gain_now);
					end
				end
			end
			// hold off once for a long stretch so the input backs up
			if (holdoff_left > 0) begin
				holdoff_left--;
				out_stall <= 1'b1;
			end else if (pace == PACE_FREE && !holdoff_done) begin
				holdoff_done = 1'b1;
				holdoff_left = HOLDOFF_CYCLES;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < idle_pct(pace, 1'b0));
			end
		end
	end

	// watchdog on beats in either direction
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int counts[6];
		counts = '{200, 60, 100, 200, 200, 120};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// full scale both ways, threshold edges, hold then decay
		program_gate(24'h200000, 24'h800000, 24'h400000, 16'd3);
		sample_backlog = '{24'h7FFFFF, 24'h800000, 24'h200000, 24'hE00000, 24'h1FFFFF,
			24'h000001, 24'h000000, 24'hFFFFFF, 24'hE00001, 24'h000000};
		drain();

		// long hold still counting, then shorten it: closing starts at once
		program_gate(24'h200000, 24'h000000, 24'h000000, 16'd40);
		sample_backlog = '{24'h400000, 24'h000010, 24'hFFFFF0, 24'h000010,
			24'h000000, 24'h000010};
		drain();
		program_gate(24'h200000, 24'h000000, 24'h000000, 16'd1);
		sample_backlog = '{24'h000000};
		drain();

		// zero threshold opens on anything
		program_gate(24'h000000, 24'hFFFFFF, 24'hFFFFFF, 16'd0);
		sample_backlog = '{24'h000000, 24'h800000};
		drain();

		// threshold above one: only the most negative sample opens
		program_gate(24'hFFFFFF, 24'h000001, 24'h000001, 16'd0);
		sample_backlog = '{24'h7FFFFF, 24'h800000};
		drain();

		// random phases across settings and pacing
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin
					pace = PACE_SRC_LIGHT;
					program_gate(CW'($urandom_range(24'h400000, 24'h008000)), COEF_BITS'($urandom),
						COEF_BITS'($urandom), HW'($urandom_range(8)));
				end
				1: begin
					pace = PACE_SRC_LIGHT;
					program_gate('0, '0, '0, '0);
				end
				2: begin
					pace = PACE_SRC_HEAVY;
					program_gate(24'h800000, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
				end
				3: begin
					pace = PACE_SRC_HEAVY;
					program_gate(CW'($urandom_range(24'h800000)), COEF_BITS'($urandom),
						COEF_BITS'($urandom), HW'($urandom_range(20)));
				end
				4: begin
					pace = PACE_FREE;
					program_gate(CW'($urandom_range(24'h600000)), COEF_BITS'($urandom),
						COEF_BITS'($urandom), HW'($urandom_range(5)));
				end
				default: begin
					pace = PACE_FREE;
					program_gate(CW'($urandom), COEF_BITS'($urandom), COEF_BITS'($urandom),
						HW'($urandom_range(3)));
				end
			endcase
			queue_bursts(counts[p]);
			drain();
		end

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
